FILE: rtl/jvm_integer_stack_execute_defines.svh
// Assertion helpers for the integer stack execute block.
`ifndef JVM_INTEGER_STACK_EXECUTE_DEFINES_SVH
`define JVM_INTEGER_STACK_EXECUTE_DEFINES_SVH
`ifndef SYNTHESIS
`define JISE_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define JISE_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define JISE_ASSERT_IMP(lbl, ante, cons, msg)
`define JISE_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/jise_pkg.sv
`timescale 1ns / 1ps
package jise_pkg;

   localparam int DATA_W       = 32;
   localparam int STACK_DEPTH  = 64;
   localparam int LOCALS_DEPTH = 256;
   localparam int QUEUE_DEPTH  = 2;
   localparam int ICONST_BIAS  = 3;

   localparam logic [7:0] OP_NOP           = 8'h00;
   localparam logic [7:0] OP_ICONST_M1     = 8'h02;
   localparam logic [7:0] OP_ICONST_5      = 8'h08;
   localparam logic [7:0] OP_BIPUSH        = 8'h10;
   localparam logic [7:0] OP_SIPUSH        = 8'h11;
   localparam logic [7:0] OP_LDC           = 8'h12;
   localparam logic [7:0] OP_ILOAD         = 8'h15;
   localparam logic [7:0] OP_ALOAD         = 8'h19;
   localparam logic [7:0] OP_ILOAD_0       = 8'h1a;
   localparam logic [7:0] OP_ILOAD_3       = 8'h1d;
   localparam logic [7:0] OP_ALOAD_0       = 8'h2a;
   localparam logic [7:0] OP_ALOAD_3       = 8'h2d;
   localparam logic [7:0] OP_ISTORE        = 8'h36;
   localparam logic [7:0] OP_ASTORE        = 8'h3a;
   localparam logic [7:0] OP_ISTORE_0      = 8'h3b;
   localparam logic [7:0] OP_ISTORE_3      = 8'h3e;
   localparam logic [7:0] OP_ASTORE_0      = 8'h4b;
   localparam logic [7:0] OP_ASTORE_3      = 8'h4e;
   localparam logic [7:0] OP_DUP           = 8'h59;
   localparam logic [7:0] OP_IADD          = 8'h60;
   localparam logic [7:0] OP_ISUB          = 8'h64;
   localparam logic [7:0] OP_IMUL          = 8'h68;
   localparam logic [7:0] OP_IDIV          = 8'h6c;
   localparam logic [7:0] OP_IREM          = 8'h70;
   localparam logic [7:0] OP_INEG          = 8'h74;
   localparam logic [7:0] OP_ISHL          = 8'h78;
   localparam logic [7:0] OP_ISHR          = 8'h7a;
   localparam logic [7:0] OP_IUSHR         = 8'h7c;
   localparam logic [7:0] OP_IAND          = 8'h7e;
   localparam logic [7:0] OP_IOR           = 8'h80;
   localparam logic [7:0] OP_IXOR          = 8'h82;
   localparam logic [7:0] OP_IINC          = 8'h84;
   localparam logic [7:0] OP_IFEQ          = 8'h99;
   localparam logic [7:0] OP_IFLE          = 8'h9e;
   localparam logic [7:0] OP_IF_ICMPEQ     = 8'h9f;
   localparam logic [7:0] OP_IF_ICMPLE     = 8'ha4;
   localparam logic [7:0] OP_GOTO          = 8'ha7;
   localparam logic [7:0] OP_IRETURN       = 8'hac;
   localparam logic [7:0] OP_ARETURN       = 8'hb0;
   localparam logic [7:0] OP_RETURN        = 8'hb1;
   localparam logic [7:0] OP_GETSTATIC     = 8'hb2;
   localparam logic [7:0] OP_INVOKEVIRTUAL = 8'hb6;

   localparam logic [2:0] REL_EQ = 3'd0;
   localparam logic [2:0] REL_NE = 3'd1;
   localparam logic [2:0] REL_LT = 3'd2;
   localparam logic [2:0] REL_GE = 3'd3;
   localparam logic [2:0] REL_GT = 3'd4;

   localparam logic [1:0] FLT_NONE   = 2'd0;
   localparam logic [1:0] FLT_DIV0   = 2'd1;
   localparam logic [1:0] FLT_OPCODE = 2'd2;
   localparam logic [1:0] FLT_STACK  = 2'd3;

   typedef enum logic [3:0] {
      CL_NOP, CL_PUSH, CL_LOAD, CL_STORE, CL_DUP, CL_BIN, CL_NEG, CL_IINC,
      CL_IF1, CL_IF2, CL_GOTO, CL_RETV, CL_RET, CL_PRINT, CL_BAD
   } cls_type;

   typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DIV, S_DFIN} state_type;

   typedef struct packed {
      logic [7:0]         kind;
      logic [7:0]         operand_byte_one;
      logic [7:0]         operand_byte_two;
      logic signed [31:0] constant_value;
   } req_type;

   typedef struct packed {
      logic [15:0]        next_pc;
      logic               print_valid;
      logic signed [31:0] print_value;
      logic               finished;
      logic               ret_valid;
      logic signed [31:0] return_value;
      logic [1:0]         fault;
   } rsp_type;

   typedef struct packed {
      cls_type     cls;
      logic [7:0]  op;
      logic [2:0]  rel;
      logic [7:0]  lidx;
      logic [31:0] imm;
      logic [15:0] off;
      logic [7:0]  delta;
      logic [1:0]  pops;
      logic [1:0]  pushes;
      logic [1:0]  len;
   } dec_type;

endpackage

FILE: rtl/jvm_integer_stack_execute.sv
// A word accepted into the queue is popped with a read of stack and locals into registers,
// then executed, and its result is registered. The execute unit pops the next word only once
// the last is done and its result is not stalled; idiv and irem take longer, bound by the
// one-bit-per-cycle divider. Synchronous active-high reset clears pc, stack pointer,
// halt flag, code size and the locals valid bits, so all locals read as zero.
`timescale 1ns / 1ps
`include "jvm_integer_stack_execute_defines.svh"
module jvm_integer_stack_execute (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  jise_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output jise_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [15:0]      csr_data
);
   import jise_pkg::*;

   logic        q_push, q_full, q_pop, q_valid;
   dec_type     q_wdata, q_rdata;
   logic [15:0] code_size_ff, code_size_in;

   assign csr_ready    = 1'b1;
   assign code_size_in = (csr_valid && csr_ready) ? csr_data : code_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         code_size_ff <= '0;
      end else begin
         code_size_ff <= code_size_in;
      end
   end

   jise_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_push    (q_push),
      .q_wdata   (q_wdata),
      .q_full    (q_full)
   );

   jise_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .full  (q_full),
      .pop   (q_pop),
      .valid (q_valid),
      .rdata (q_rdata)
   );

   jise_back u_back (
      .clock       (clock),
      .reset       (reset),
      .code_size   (code_size_ff),
      .q_valid     (q_valid),
      .q_data      (q_rdata),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   `JISE_ASSERT_IMP(a_fault_not_finished, rsp_valid && (rsp_data.fault != FLT_NONE),
                    !rsp_data.finished, "faulted word reports finished")
   `JISE_ASSERT_IMP(a_value_needs_finish, rsp_valid && rsp_data.ret_valid,
                    rsp_data.finished, "return value without finish")
   `JISE_ASSERT_NXT(a_pop_spacing, q_pop, !q_pop,
                    "execute unit popped two words back to back")
   `JISE_ASSERT_IMP(a_no_push_when_full, q_push, !q_full, "queue pushed while full")

endmodule

FILE: rtl/jise_front.sv
`timescale 1ns / 1ps
module jise_front (
   input  logic             req_valid,
   output logic             req_stall,
   input  jise_pkg::req_type req_data,
   output logic             q_push,
   output jise_pkg::dec_type q_wdata,
   input  logic             q_full
);
   import jise_pkg::*;

   logic [7:0] kind;

   assign kind      = req_data.kind;
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_wdata        = '0;
      q_wdata.cls    = CL_BAD;
      q_wdata.op     = kind;
      q_wdata.off    = {req_data.operand_byte_one, req_data.operand_byte_two};
      q_wdata.delta  = req_data.operand_byte_two;
      q_wdata.lidx   = req_data.operand_byte_one;
      q_wdata.len    = 2'd1;
      unique case (kind) inside
         OP_NOP: q_wdata.cls = CL_NOP;
         OP_GETSTATIC: begin
            q_wdata.cls = CL_NOP;
            q_wdata.len = 2'd3;
         end
         [OP_ICONST_M1:OP_ICONST_5]: begin
            q_wdata.cls    = CL_PUSH;
            q_wdata.pushes = 2'd1;
            q_wdata.imm    = 32'(kind) - 32'(ICONST_BIAS);
         end
         OP_BIPUSH: begin
            q_wdata.cls    = CL_PUSH;
            q_wdata.pushes = 2'd1;
            q_wdata.len    = 2'd2;
            q_wdata.imm    = {{24{req_data.operand_byte_one[7]}}, req_data.operand_byte_one};
         end
         OP_SIPUSH: begin
            q_wdata.cls    = CL_PUSH;
            q_wdata.pushes = 2'd1;
            q_wdata.len    = 2'd3;
            q_wdata.imm    = {{16{req_data.operand_byte_one[7]}},
                              req_data.operand_byte_one, req_data.operand_byte_two};
         end
         OP_LDC: begin
            q_wdata.cls    = CL_PUSH;
            q_wdata.pushes = 2'd1;
            q_wdata.len    = 2'd2;
            q_wdata.imm    = req_data.constant_value;
         end
         OP_ILOAD, OP_ALOAD: begin
            q_wdata.cls    = CL_LOAD;
            q_wdata.pushes = 2'd1;
            q_wdata.len    = 2'd2;
         end
         [OP_ILOAD_0:OP_ILOAD_3]: begin
            q_wdata.cls    = CL_LOAD;
            q_wdata.pushes = 2'd1;
            q_wdata.lidx   = kind - OP_ILOAD_0;
         end
         [OP_ALOAD_0:OP_ALOAD_3]: begin
            q_wdata.cls    = CL_LOAD;
            q_wdata.pushes = 2'd1;
            q_wdata.lidx   = kind - OP_ALOAD_0;
         end
         OP_ISTORE, OP_ASTORE: begin
            q_wdata.cls  = CL_STORE;
            q_wdata.pops = 2'd1;
            q_wdata.len  = 2'd2;
         end
         [OP_ISTORE_0:OP_ISTORE_3]: begin
            q_wdata.cls  = CL_STORE;
            q_wdata.pops = 2'd1;
            q_wdata.lidx = kind - OP_ISTORE_0;
         end
         [OP_ASTORE_0:OP_ASTORE_3]: begin
            q_wdata.cls  = CL_STORE;
            q_wdata.pops = 2'd1;
            q_wdata.lidx = kind - OP_ASTORE_0;
         end
         OP_DUP: begin
            q_wdata.cls    = CL_DUP;
            q_wdata.pops   = 2'd1;
            q_wdata.pushes = 2'd2;
         end
         OP_IADD, OP_ISUB, OP_IMUL, OP_IDIV, OP_IREM, OP_ISHL, OP_ISHR, OP_IUSHR,
         OP_IAND, OP_IOR, OP_IXOR: begin
            q_wdata.cls    = CL_BIN;
            q_wdata.pops   = 2'd2;
            q_wdata.pushes = 2'd1;
         end
         OP_INEG: begin
            q_wdata.cls    = CL_NEG;
            q_wdata.pops   = 2'd1;
            q_wdata.pushes = 2'd1;
         end
         OP_IINC: begin
            q_wdata.cls = CL_IINC;
            q_wdata.len = 2'd3;
         end
         [OP_IFEQ:OP_IFLE]: begin
            q_wdata.cls  = CL_IF1;
            q_wdata.pops = 2'd1;
            q_wdata.len  = 2'd3;
            q_wdata.rel  = 3'(kind - OP_IFEQ);
         end
         [OP_IF_ICMPEQ:OP_IF_ICMPLE]: begin
            q_wdata.cls  = CL_IF2;
            q_wdata.pops = 2'd2;
            q_wdata.len  = 2'd3;
            q_wdata.rel  = 3'(kind - OP_IF_ICMPEQ);
         end
         OP_GOTO: q_wdata.cls = CL_GOTO;
         OP_IRETURN, OP_ARETURN: begin
            q_wdata.cls  = CL_RETV;
            q_wdata.pops = 2'd1;
         end
         OP_RETURN: q_wdata.cls = CL_RET;
         OP_INVOKEVIRTUAL: begin
            q_wdata.cls  = CL_PRINT;
            q_wdata.pops = 2'd1;
            q_wdata.len  = 2'd3;
         end
         default: q_wdata.cls = CL_BAD;
      endcase
   end

endmodule

FILE: rtl/jise_queue.sv
`timescale 1ns / 1ps
module jise_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  jise_pkg::dec_type wdata,
   output logic             full,
   input  logic             pop,
   output logic             valid,
   output jise_pkg::dec_type rdata
);
   import jise_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   dec_type             slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   assign full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign valid = (count_ff != '0);
   assign rdata = slot_ff[rd_ptr_ff];

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      bump = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

FILE: rtl/jise_back.sv
`timescale 1ns / 1ps
module jise_back (
   input  logic             clock,
   input  logic             reset,
   input  logic [15:0]      code_size,
   input  logic             q_valid,
   input  jise_pkg::dec_type q_data,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output jise_pkg::rsp_type rsp_data
);
   import jise_pkg::*;

   localparam int SP_W  = $clog2(STACK_DEPTH + 1);
   localparam int SK_AW = $clog2(STACK_DEPTH);
   localparam int LV_AW = $clog2(LOCALS_DEPTH);
   localparam int DC_W  = $clog2(DATA_W);

   logic [DATA_W-1:0]       stk_mem [STACK_DEPTH];
   logic [DATA_W-1:0]       lv_mem [LOCALS_DEPTH];
   logic [LOCALS_DEPTH-1:0] lv_valid_ff, lv_valid_in;

   state_type         state_ff, state_in;
   dec_type           cur_ff, cur_in;
   logic [SP_W-1:0]   sp_ff, sp_in, sp_m1, sp_m2;
   logic [15:0]       pc_ff, pc_in, npc;
   logic              halted_ff, halted_in;
   logic              out_valid_ff, out_valid_in;
   rsp_type           out_ff, out_in, res;
   logic              done;

   logic [DATA_W-1:0] top_ff, sec_ff, lv_rd_ff, lv_val, alu;
   logic              lv_hit_ff;
   logic              fits;
   logic [SP_W:0]     sp_after;

   logic              stk_we, lv_we;
   logic [SK_AW-1:0]  stk_wa;
   logic [LV_AW-1:0]  lv_wa;
   logic [DATA_W-1:0] stk_wd, lv_wd;

   logic [DATA_W-1:0] dv_q_ff, dv_q_in, dv_r_ff, dv_r_in, dv_b_ff, dv_b_in, dv_res;
   logic [DATA_W:0]   dv_trial;
   logic [DC_W-1:0]   dv_cnt_ff, dv_cnt_in;
   logic              dv_rem_ff, dv_rem_in, dv_na_ff, dv_na_in, dv_neg_ff, dv_neg_in;

   function automatic logic idx_ok(input logic [7:0] idx);
      idx_ok = ({1'b0, idx} < 9'(LOCALS_DEPTH));
   endfunction

   function automatic logic rel_true(input logic [2:0] rel, input logic [DATA_W-1:0] a,
                                     input logic [DATA_W-1:0] b);
      unique case (rel)
         REL_EQ:  rel_true = (a == b);
         REL_NE:  rel_true = (a != b);
         REL_LT:  rel_true = ($signed(a) < $signed(b));
         REL_GE:  rel_true = !($signed(a) < $signed(b));
         REL_GT:  rel_true = ($signed(b) < $signed(a));
         default: rel_true = !($signed(b) < $signed(a));
      endcase
   endfunction

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
   assign sp_m1     = sp_ff - 1'b1;
   assign sp_m2     = sp_ff - 2'd2;
   assign lv_val    = lv_hit_ff ? lv_rd_ff : '0;

   assign sp_after = {1'b0, sp_ff} + (SP_W + 1)'(cur_ff.pushes) - (SP_W + 1)'(cur_ff.pops);
   assign fits     = (sp_ff >= SP_W'(cur_ff.pops)) && (sp_after <= (SP_W + 1)'(STACK_DEPTH));

   always_comb begin
      unique case (cur_ff.op)
         OP_IADD:  alu = sec_ff + top_ff;
         OP_ISUB:  alu = sec_ff - top_ff;
         OP_IMUL:  alu = sec_ff * top_ff;
         OP_ISHL:  alu = sec_ff << top_ff[4:0];
         OP_ISHR:  alu = $unsigned($signed(sec_ff) >>> top_ff[4:0]);
         OP_IUSHR: alu = sec_ff >> top_ff[4:0];
         OP_IAND:  alu = sec_ff & top_ff;
         OP_IOR:   alu = sec_ff | top_ff;
         default:  alu = sec_ff ^ top_ff;
      endcase
   end

   assign dv_trial = {dv_r_ff, dv_q_ff[DATA_W-1]} - {1'b0, dv_b_ff};
   assign dv_res   = dv_rem_ff ? (dv_na_ff ? -dv_r_ff : dv_r_ff)
                               : (dv_neg_ff ? -dv_q_ff : dv_q_ff);

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      sp_in        = sp_ff;
      pc_in        = pc_ff;
      halted_in    = halted_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_in       = out_ff;
      q_pop        = 1'b0;
      done         = 1'b0;
      npc          = pc_ff;
      res          = '0;
      res.next_pc  = pc_ff;
      stk_we       = 1'b0;
      stk_wa       = sp_ff[SK_AW-1:0];
      stk_wd       = cur_ff.imm;
      lv_we        = 1'b0;
      lv_wa        = cur_ff.lidx[LV_AW-1:0];
      lv_wd        = top_ff;
      dv_q_in      = dv_q_ff;
      dv_r_in      = dv_r_ff;
      dv_b_in      = dv_b_ff;
      dv_cnt_in    = dv_cnt_ff;
      dv_rem_in    = dv_rem_ff;
      dv_na_in     = dv_na_ff;
      dv_neg_in    = dv_neg_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid && (!out_valid_ff || !rsp_stall)) begin
               q_pop    = 1'b1;
               cur_in   = q_data;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
            done     = 1'b1;
            if (halted_ff || pc_ff >= code_size) begin
               res.finished = 1'b1;
               halted_in    = 1'b1;
            end else if (cur_ff.cls == CL_BAD) begin
               res.fault = FLT_OPCODE;
            end else if (!fits) begin
               res.fault = FLT_STACK;
            end else begin
               npc = pc_ff + 16'(cur_ff.len);
               unique case (cur_ff.cls)
                  CL_PUSH: begin
                     stk_we = 1'b1;
                     sp_in  = sp_ff + 1'b1;
                  end
                  CL_LOAD: begin
                     stk_we = 1'b1;
                     stk_wd = lv_val;
                     sp_in  = sp_ff + 1'b1;
                  end
                  CL_STORE: begin
                     lv_we = idx_ok(cur_ff.lidx);
                     sp_in = sp_m1;
                  end
                  CL_DUP: begin
                     stk_we = 1'b1;
                     stk_wd = top_ff;
                     sp_in  = sp_ff + 1'b1;
                  end
                  CL_BIN: begin
                     if (cur_ff.op == OP_IDIV || cur_ff.op == OP_IREM) begin
                        if (top_ff == '0) begin
                           res.fault = FLT_DIV0;
                        end else begin
                           // hand off to the shift-subtract divider on magnitudes
                           done      = 1'b0;
                           state_in  = S_DIV;
                           dv_na_in  = sec_ff[DATA_W-1];
                           dv_neg_in = sec_ff[DATA_W-1] ^ top_ff[DATA_W-1];
                           dv_rem_in = (cur_ff.op == OP_IREM);
                           dv_q_in   = sec_ff[DATA_W-1] ? -sec_ff : sec_ff;
                           dv_b_in   = top_ff[DATA_W-1] ? -top_ff : top_ff;
                           dv_r_in   = '0;
                           dv_cnt_in = '0;
                        end
                     end else begin
                        stk_we = 1'b1;
                        stk_wa = sp_m2[SK_AW-1:0];
                        stk_wd = alu;
                        sp_in  = sp_m1;
                     end
                  end
                  CL_NEG: begin
                     stk_we = 1'b1;
                     stk_wa = sp_m1[SK_AW-1:0];
                     stk_wd = -top_ff;
                  end
                  CL_IINC: begin
                     lv_we = idx_ok(cur_ff.lidx);
                     lv_wd = lv_val + {{24{cur_ff.delta[7]}}, cur_ff.delta};
                  end
                  CL_IF1: begin
                     if (rel_true(cur_ff.rel, top_ff, '0)) npc = pc_ff + cur_ff.off;
                     sp_in = sp_m1;
                  end
                  CL_IF2: begin
                     if (rel_true(cur_ff.rel, sec_ff, top_ff)) npc = pc_ff + cur_ff.off;
                     sp_in = sp_m2;
                  end
                  CL_GOTO: npc = pc_ff + cur_ff.off;
                  CL_RETV: begin
                     npc              = pc_ff;
                     res.return_value = top_ff;
                     res.ret_valid    = 1'b1;
                     res.finished     = 1'b1;
                     halted_in        = 1'b1;
                     sp_in            = sp_m1;
                  end
                  CL_RET: begin
                     npc          = pc_ff;
                     res.finished = 1'b1;
                     halted_in    = 1'b1;
                  end
                  CL_PRINT: begin
                     res.print_valid = 1'b1;
                     res.print_value = top_ff;
                     sp_in           = sp_m1;
                  end
                  default: ;
               endcase
               if (res.fault == FLT_NONE) begin
                  res.next_pc = npc;
                  if (!res.finished && npc >= code_size) begin
                     res.finished = 1'b1;
                     halted_in    = 1'b1;
                  end
               end
            end
         end
         S_DIV: begin
            if (!dv_trial[DATA_W]) begin
               dv_r_in = dv_trial[DATA_W-1:0];
               dv_q_in = {dv_q_ff[DATA_W-2:0], 1'b1};
            end else begin
               dv_r_in = {dv_r_ff[DATA_W-2:0], dv_q_ff[DATA_W-1]};
               dv_q_in = {dv_q_ff[DATA_W-2:0], 1'b0};
            end
            dv_cnt_in = dv_cnt_ff + 1'b1;
            if (dv_cnt_ff == DC_W'(DATA_W - 1)) state_in = S_DFIN;
         end
         S_DFIN: begin
            state_in    = S_IDLE;
            done        = 1'b1;
            stk_we      = 1'b1;
            stk_wa      = sp_m2[SK_AW-1:0];
            stk_wd      = dv_res;
            sp_in       = sp_m1;
            npc         = pc_ff + 1'b1;
            res.next_pc = npc;
            if (npc >= code_size) begin
               res.finished = 1'b1;
               halted_in    = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (done) begin
         out_valid_in = 1'b1;
         out_in       = res;
         pc_in        = res.next_pc;
      end

      lv_valid_in = lv_valid_ff;
      if (lv_we) lv_valid_in[lv_wa] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sp_ff        <= '0;
         pc_ff        <= '0;
         halted_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
         lv_valid_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         pc_ff        <= pc_in;
         halted_ff    <= halted_in;
         out_valid_ff <= out_valid_in;
         lv_valid_ff  <= lv_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      out_ff    <= out_in;
      dv_q_ff   <= dv_q_in;
      dv_r_ff   <= dv_r_in;
      dv_b_ff   <= dv_b_in;
      dv_cnt_ff <= dv_cnt_in;
      dv_rem_ff <= dv_rem_in;
      dv_na_ff  <= dv_na_in;
      dv_neg_ff <= dv_neg_in;
   end

   // stack: one write, two reads at top and second
   always_ff @(posedge clock) begin
      if (stk_we) stk_mem[stk_wa] <= stk_wd;
      top_ff <= stk_mem[sp_m1[SK_AW-1:0]];
      sec_ff <= stk_mem[sp_m2[SK_AW-1:0]];
   end

   // locals: read at the index of the word at the queue head
   always_ff @(posedge clock) begin
      if (lv_we) lv_mem[lv_wa] <= lv_wd;
      lv_rd_ff  <= lv_mem[q_data.lidx[LV_AW-1:0]];
      lv_hit_ff <= lv_valid_ff[q_data.lidx[LV_AW-1:0]] && idx_ok(q_data.lidx);
   end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import jise_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = '0;

   jvm_integer_stack_execute dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   // shadow machine state
   logic [31:0] stk [STACK_DEPTH];
   logic [31:0] lvars [LOCALS_DEPTH];
   int          sp = 0;
   logic [15:0] pc = '0;
   logic        halted = 1'b0;
   logic [15:0] code_len = '0;

   rsp_type pending_rsp[$];
   int      errors = 0;
   int      words_sent = 0;
   int      words_checked = 0;
   int      send_gap_pct = 0;
   int      stall_pct = 0;
   int      hold_left = 0;
   int      branch_limit = 3000;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("FAIL jvm_integer_stack_execute");
      $finish;
   end

   function automatic bit room(int pops, int pushes);
      return sp >= pops && sp - pops + pushes <= STACK_DEPTH;
   endfunction

   function automatic bit holds(logic [2:0] rel, logic [31:0] a, logic [31:0] b);
      case (rel)
         REL_EQ: return a == b;
         REL_NE: return a != b;
         REL_LT: return $signed(a) < $signed(b);
         REL_GE: return $signed(a) >= $signed(b);
         REL_GT: return $signed(a) > $signed(b);
         default: return $signed(a) <= $signed(b);
      endcase
   endfunction

   // Execute one instruction on the shadow state and return its result word.
   function automatic rsp_type execute_word(req_type w);
      rsp_type     o;
      logic [7:0]  op;
      logic [15:0] off, npc;
      logic [31:0] a, b, r;
      logic [1:0]  flt;
      o = '0;
      op = w.kind;
      off = {w.operand_byte_one, w.operand_byte_two};
      npc = pc;
      flt = FLT_NONE;
      if (halted || pc >= code_len) begin
         halted = 1'b1;
         o.finished = 1'b1;
      end else begin
         if (op == OP_NOP) begin
            npc = pc + 16'd1;
         end else if (op >= OP_ICONST_M1 && op <= OP_ICONST_5) begin
            if (!room(0, 1)) flt = FLT_STACK;
            else begin
               stk[sp] = 32'(op) - 32'(ICONST_BIAS); sp++; npc = pc + 16'd1;
            end
         end else if (op == OP_BIPUSH || op == OP_SIPUSH || op == OP_LDC ||
                      op == OP_ILOAD || op == OP_ALOAD) begin
            if (!room(0, 1)) flt = FLT_STACK;
            else begin
               if (op == OP_BIPUSH) stk[sp] = {{24{w.operand_byte_one[7]}}, w.operand_byte_one};
               else if (op == OP_SIPUSH) stk[sp] = {{16{off[15]}}, off};
               else if (op == OP_LDC) stk[sp] = w.constant_value;
               else stk[sp] = lvars[w.operand_byte_one];
               sp++;
               npc = pc + ((op == OP_SIPUSH) ? 16'd3 : 16'd2);
            end
         end else if ((op >= OP_ILOAD_0 && op <= OP_ILOAD_3) ||
                      (op >= OP_ALOAD_0 && op <= OP_ALOAD_3)) begin
            if (!room(0, 1)) flt = FLT_STACK;
            else begin
               stk[sp] = lvars[op < OP_ALOAD_0 ? op - OP_ILOAD_0 : op - OP_ALOAD_0];
               sp++; npc = pc + 16'd1;
            end
         end else if (op == OP_ISTORE || op == OP_ASTORE) begin
            if (!room(1, 0)) flt = FLT_STACK;
            else begin
               lvars[w.operand_byte_one] = stk[sp-1]; sp--; npc = pc + 16'd2;
            end
         end else if ((op >= OP_ISTORE_0 && op <= OP_ISTORE_3) ||
                      (op >= OP_ASTORE_0 && op <= OP_ASTORE_3)) begin
            if (!room(1, 0)) flt = FLT_STACK;
            else begin
               lvars[op < OP_ASTORE_0 ? op - OP_ISTORE_0 : op - OP_ASTORE_0] = stk[sp-1];
               sp--; npc = pc + 16'd1;
            end
         end else if (op == OP_DUP) begin
            if (!room(1, 2)) flt = FLT_STACK;
            else begin
               stk[sp] = stk[sp-1]; sp++; npc = pc + 16'd1;
            end
         end else if (op == OP_IADD || op == OP_ISUB || op == OP_IMUL || op == OP_IDIV ||
                      op == OP_IREM || op == OP_ISHL || op == OP_ISHR || op == OP_IUSHR ||
                      op == OP_IAND || op == OP_IOR || op == OP_IXOR) begin
            if (!room(2, 1)) flt = FLT_STACK;
            else begin
               a = stk[sp-2];
               b = stk[sp-1];
               r = '0;
               case (op)
                  OP_IADD: r = a + b;
                  OP_ISUB: r = a - b;
                  OP_IMUL: r = a * b;
                  OP_IDIV, OP_IREM: begin
                     if (b == 0) flt = FLT_DIV0;
                     else if (a == 32'h8000_0000 && b == 32'hffff_ffff)
                        r = (op == OP_IDIV) ? a : 32'd0;
                     else if (op == OP_IDIV) r = $signed(a) / $signed(b);
                     else r = $signed(a) % $signed(b);
                  end
                  OP_ISHL: r = a << b[4:0];
                  OP_ISHR: r = $signed(a) >>> b[4:0];
                  OP_IUSHR: r = a >> b[4:0];
                  OP_IAND: r = a & b;
                  OP_IOR: r = a | b;
                  default: r = a ^ b;
               endcase
               if (flt == FLT_NONE) begin
                  stk[sp-2] = r; sp--; npc = pc + 16'd1;
               end
            end
         end else if (op == OP_INEG) begin
            if (!room(1, 1)) flt = FLT_STACK;
            else begin
               stk[sp-1] = 32'd0 - stk[sp-1]; npc = pc + 16'd1;
            end
         end else if (op == OP_IINC) begin
            lvars[w.operand_byte_one] = lvars[w.operand_byte_one] +
               {{24{w.operand_byte_two[7]}}, w.operand_byte_two};
            npc = pc + 16'd3;
         end else if (op >= OP_IFEQ && op <= OP_IFLE) begin
            if (!room(1, 0)) flt = FLT_STACK;
            else begin
               npc = holds(3'(op - OP_IFEQ), stk[sp-1], 32'd0) ? pc + off : pc + 16'd3;
               sp--;
            end
         end else if (op >= OP_IF_ICMPEQ && op <= OP_IF_ICMPLE) begin
            if (!room(2, 0)) flt = FLT_STACK;
            else begin
               npc = holds(3'(op - OP_IF_ICMPEQ), stk[sp-2], stk[sp-1]) ? pc + off
                                                                       : pc + 16'd3;
               sp -= 2;
            end
         end else if (op == OP_GOTO) begin
            npc = pc + off;
         end else if (op == OP_IRETURN || op == OP_ARETURN) begin
            if (!room(1, 0)) flt = FLT_STACK;
            else begin
               o.return_value = stk[sp-1]; o.ret_valid = 1'b1; o.finished = 1'b1;
               sp--; halted = 1'b1;
            end
         end else if (op == OP_RETURN) begin
            o.finished = 1'b1; halted = 1'b1;
         end else if (op == OP_GETSTATIC) begin
            npc = pc + 16'd3;
         end else if (op == OP_INVOKEVIRTUAL) begin
            if (!room(1, 0)) flt = FLT_STACK;
            else begin
               o.print_valid = 1'b1; o.print_value = stk[sp-1]; sp--; npc = pc + 16'd3;
            end
         end else begin
            flt = FLT_OPCODE;
         end
         if (flt != FLT_NONE) npc = pc;
         else if (!o.finished && npc >= code_len) begin
            o.finished = 1'b1; halted = 1'b1;
         end
      end
      o.fault = flt;
      pc = npc;
      o.next_pc = npc;
      return o;
   endfunction

   task automatic send_word(req_type w);
      if ($urandom_range(0, 99) < send_gap_pct) begin
         repeat ($urandom_range(1, 3)) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (req_stall);
      pending_rsp.push_back(execute_word(w));
      words_sent++;
   endtask

   task automatic send_op(logic [7:0] kind, logic [7:0] b1 = 8'd0, logic [7:0] b2 = 8'd0,
                          logic [31:0] k = 32'd0);
      req_type w;
      w.kind = kind;
      w.operand_byte_one = b1;
      w.operand_byte_two = b2;
      w.constant_value = k;
      send_word(w);
   endtask

   task automatic drain;
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_rsp.size() == 0);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_code_length(logic [15:0] v);
      drain();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      code_len = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // back to pc 0 so that a shorter code length does not end the method
   task automatic rewind_pc;
      logic [15:0] off;
      off = 16'd0 - pc;
      send_op(OP_GOTO, off[15:8], off[7:0]);
   endtask

   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   task automatic report(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected word, got %h", $time, rsp_data);
            errors++;
         end else begin
            want = pending_rsp.pop_front();
            report("next_pc", want.next_pc, rsp_data.next_pc);
            report("print_valid", want.print_valid, rsp_data.print_valid);
            report("print_value", want.print_value, rsp_data.print_value);
            report("finished", want.finished, rsp_data.finished);
            report("ret_valid", want.ret_valid, rsp_data.ret_valid);
            report("return_value", want.return_value, rsp_data.return_value);
            report("fault", want.fault, rsp_data.fault);
            words_checked++;
         end
      end
   end

   task automatic test_directed;
      send_op(OP_IADD);                               // underflow on empty stack
      send_op(OP_ICONST_M1);
      send_op(OP_ICONST_5);
      send_op(OP_BIPUSH, 8'h80);
      send_op(OP_SIPUSH, 8'h80, 8'h00);
      send_op(OP_LDC, 8'd1, 8'd0, 32'h8000_0000);
      send_op(OP_LDC, 8'd1, 8'd0, 32'hffff_ffff);
      send_op(OP_IDIV);                               // MIN / -1
      send_op(OP_DUP);
      send_op(OP_ICONST_M1 + 8'd1);
      send_op(OP_IDIV);                               // divide by zero
      send_op(OP_IREM);
      send_op(OP_LDC, 8'd1, 8'd0, 32'h7fff_ffff);
      send_op(OP_LDC, 8'd1, 8'd0, 32'd33);
      send_op(OP_ISHL);                               // count uses low five bits
      send_op(OP_INEG);
      send_op(OP_ISTORE, 8'hff);
      send_op(OP_IINC, 8'hff, 8'h80);
      send_op(OP_ILOAD, 8'hff);
      send_op(OP_INVOKEVIRTUAL);
      send_op(OP_IF_ICMPLE, 8'h00, 8'h05);
      send_op(OP_GETSTATIC);
      send_op(OP_GOTO, 8'hff, 8'hfd);                 // backward branch
      send_op(8'hb8);                                 // invokestatic is not handled
      send_op(8'hff);
   endtask

   function automatic req_type make_word;
      req_type     w;
      logic [15:0] off;
      int          pick;
      logic [7:0]  ops [] = '{OP_NOP, OP_ICONST_M1, OP_ICONST_5, OP_ICONST_M1 + 8'd3,
         OP_BIPUSH, OP_SIPUSH, OP_LDC, OP_LDC, OP_ILOAD, OP_ALOAD, OP_ILOAD_0, OP_ILOAD_3,
         OP_ALOAD_0, OP_ALOAD_3, OP_ISTORE, OP_ASTORE, OP_ISTORE_0, OP_ISTORE_3,
         OP_ASTORE_0, OP_ASTORE_3, OP_DUP, OP_IADD, OP_ISUB, OP_IMUL, OP_IDIV, OP_IREM,
         OP_INEG, OP_ISHL, OP_ISHR, OP_IUSHR, OP_IAND, OP_IOR, OP_IXOR, OP_IINC,
         OP_IFEQ, OP_IFEQ + 8'd1, OP_IFEQ + 8'd2, OP_IFEQ + 8'd3, OP_IFEQ + 8'd4, OP_IFLE,
         OP_IF_ICMPEQ, OP_IF_ICMPEQ + 8'd1, OP_IF_ICMPEQ + 8'd2, OP_IF_ICMPEQ + 8'd3,
         OP_IF_ICMPEQ + 8'd4, OP_IF_ICMPLE, OP_GOTO, OP_GETSTATIC, OP_INVOKEVIRTUAL};
      w.kind             = 8'($urandom);
      w.operand_byte_one = 8'($urandom);
      w.operand_byte_two = 8'($urandom);
      w.constant_value   = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
         // noise opcode; keep the method running
         if (w.kind == OP_IRETURN || w.kind == OP_ARETURN || w.kind == OP_RETURN)
            w.kind = OP_NOP;
      end else begin
         w.kind = ops[$urandom_range(0, ops.size() - 1)];
      end
      if (pick < 30) begin
         case ($urandom_range(0, 4))
            0: w.constant_value = 0;
            1: w.constant_value = -1;
            2: w.constant_value = 32'sh8000_0000;
            3: w.constant_value = 32'sh7fff_ffff;
            default: w.constant_value = $urandom_range(0, 40);
         endcase
      end
      if (pc > branch_limit) w.kind = OP_GOTO;
      if (w.kind == OP_GOTO || (w.kind >= OP_IFEQ && w.kind <= OP_IF_ICMPLE)) begin
         off = 16'($urandom_range(0, branch_limit)) - pc;
         {w.operand_byte_one, w.operand_byte_two} = off;
      end
      return w;
   endfunction

   task automatic test_random(int n, int gap, int stall);
      send_gap_pct = gap;
      stall_pct = stall;
      repeat (n) send_word(make_word());
   endtask

   // Hold the receiver off while words keep coming, then overflow the stack.
   task automatic test_backpressure;
      send_gap_pct = 0;
      stall_pct = 0;
      hold_left = 300;
      repeat (STACK_DEPTH + 4) send_op(OP_BIPUSH, 8'($urandom));
      repeat (STACK_DEPTH - 2) send_op(OP_ISTORE, 8'($urandom));
   endtask

   task automatic test_return;
      send_op(OP_LDC, 8'd1, 8'd0, 32'h8765_4321);
      send_op(OP_IRETURN);
      send_op(OP_ICONST_5);                           // halted: nothing runs
      send_op(OP_RETURN);
      write_code_length(16'd0);
      send_op(OP_NOP);
   endtask

   initial begin
      for (int i = 0; i < LOCALS_DEPTH; i++) lvars[i] = '0;
      for (int i = 0; i < STACK_DEPTH; i++) stk[i] = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      write_code_length(16'hffff);
      test_directed();
      test_random(160, 10, 58);
      test_backpressure();
      rewind_pc();
      branch_limit = 900;
      write_code_length(16'd1000);
      test_random(160, 58, 10);
      rewind_pc();
      branch_limit = 3000;
      write_code_length(16'hffff);
      test_random(160, 0, 0);
      test_return();
      drain();
      $display("Ran %0d instruction words, %0d results checked, across code lengths",
               words_sent, words_checked);
      $display("max, 1000 and 0, with stalls, stack overflow, faults and a value return.");
      if (errors == 0) begin
         $display("PASS jvm_integer_stack_execute");
      end else begin
         $display("FAIL jvm_integer_stack_execute");
      end
      $finish;
   end

endmodule
